// File: hw/rtl/esd_pkg.sv
// Shared types and constants for the escape sequence decoder.
// Holds the classified character token, the character and control codes and the hex digit counts.
// No dependencies.
`default_nettype none

package esd_pkg;

	// Character codes that the classifier looks for.
	localparam logic [15:0] CH_BSLASH = 16'h005C;
	localparam logic [15:0] CH_DIG0   = 16'h0030;
	localparam logic [15:0] CH_DIG9   = 16'h0039;
	localparam logic [15:0] CH_LA     = 16'h0061;
	localparam logic [15:0] CH_LF     = 16'h0066;
	localparam logic [15:0] CH_UA     = 16'h0041;
	localparam logic [15:0] CH_UF     = 16'h0046;
	localparam logic [15:0] CH_LX     = 16'h0078;
	localparam logic [15:0] CH_LU     = 16'h0075;
	localparam logic [15:0] CH_LB     = 16'h0062;
	localparam logic [15:0] CH_LN     = 16'h006E;
	localparam logic [15:0] CH_LR     = 16'h0072;
	localparam logic [15:0] CH_LT     = 16'h0074;
	localparam logic [15:0] CH_LV     = 16'h0076;

	// Control codes produced by the single-letter escapes.
	localparam logic [15:0] CC_BEL = 16'd7;
	localparam logic [15:0] CC_BS  = 16'd8;
	localparam logic [15:0] CC_HT  = 16'd9;
	localparam logic [15:0] CC_LF  = 16'd10;
	localparam logic [15:0] CC_VT  = 16'd11;
	localparam logic [15:0] CC_FF  = 16'd12;
	localparam logic [15:0] CC_CR  = 16'd13;

	// Digit counts for the two hex escapes.
	localparam logic [2:0] DIGITS_X = 3'd2;
	localparam logic [2:0] DIGITS_U = 3'd4;

	// One character after classification by the front end.
	typedef struct packed {
		logic [15:0] ch;        // raw character
		logic [15:0] esc_val;   // value if taken as a single-letter escape
		logic        eos;       // last character of the string
		logic        is_bslash;
		logic        is_x;
		logic        is_u;
		logic        hex_ok;
		logic [3:0]  hex_val;
	} esd_tok_t;

endpackage

`default_nettype wire

// File: hw/rtl/esd_front.sv
// Front end of the escape sequence decoder: accepts characters and classifies them.
// Depends on esd_pkg.
`default_nettype none

module esd_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire  [15:0]           in_ch,
	input  wire                   in_eos,
	output logic                  tok_valid,
	input  wire                   tok_ready,
	output esd_pkg::esd_tok_t     tok
);
	import esd_pkg::*;

	logic      valid_s1;
	esd_tok_t  tok_s1;
	esd_tok_t  tok_d;
	logic      is_dec;
	logic      is_lhex;
	logic      is_uhex;

	// Classify the incoming character.
	always_comb begin
		is_dec  = (in_ch >= CH_DIG0) && (in_ch <= CH_DIG9);
		is_lhex = (in_ch >= CH_LA) && (in_ch <= CH_LF);
		is_uhex = (in_ch >= CH_UA) && (in_ch <= CH_UF);
		tok_d.ch        = in_ch;
		tok_d.eos       = in_eos;
		tok_d.is_bslash = (in_ch == CH_BSLASH);
		tok_d.is_x      = (in_ch == CH_LX);
		tok_d.is_u      = (in_ch == CH_LU);
		tok_d.hex_ok    = is_dec || is_lhex || is_uhex;
		// Letters a-f and A-F have low nibbles 1 to 6, giving 10 to 15 with nine added.
		if (is_dec) begin
			tok_d.hex_val = in_ch[3:0];
		end else begin
			tok_d.hex_val = in_ch[3:0] + 4'd9;
		end
		unique case (in_ch)
			CH_LA:   tok_d.esc_val = CC_BEL;
			CH_LB:   tok_d.esc_val = CC_BS;
			CH_LF:   tok_d.esc_val = CC_FF;
			CH_LN:   tok_d.esc_val = CC_LF;
			CH_LR:   tok_d.esc_val = CC_CR;
			CH_LT:   tok_d.esc_val = CC_HT;
			CH_LV:   tok_d.esc_val = CC_VT;
			default: tok_d.esc_val = in_ch;
		endcase
	end

	// The stage takes a new request when empty or when its token moves on.
	assign in_ready = !valid_s1 || tok_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			tok_s1 <= tok_d;
		end
	end

	assign tok_valid = valid_s1;
	assign tok       = tok_s1;

endmodule

`default_nettype wire

// File: hw/rtl/esd_fifo.sv
// Token queue between the front and back ends of the escape sequence decoder.
// Depends on esd_pkg.
`default_nettype none

module esd_fifo #(
	parameter int DEPTH = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   wr_valid,
	output logic                  wr_ready,
	input  esd_pkg::esd_tok_t     wr_tok,
	output logic                  rd_valid,
	input  wire                   rd_ready,
	output esd_pkg::esd_tok_t     rd_tok
);
	import esd_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	esd_tok_t        mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            push;
	logic            pop;

	assign wr_ready = (count_q != CW'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_tok   = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_tok;
		end
	end

	// Pointers wrap at the depth; the count tracks occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/esd_back.sv
// Back end of the escape sequence decoder: escape state machine and output register.
// Depends on esd_pkg.
`default_nettype none

module esd_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   tok_valid,
	output logic                  tok_ready,
	input  esd_pkg::esd_tok_t     tok,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [15:0]           out_char,
	output logic                  out_has_char,
	output logic                  out_error,
	output logic                  out_done
);
	import esd_pkg::*;

	// Decoder modes.
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_ESC  = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;
	localparam logic [1:0] MODE_DROP = 2'd3;

	logic [1:0]  mode_q;
	logic [2:0]  digits_q;
	logic [15:0] acc_q;
	logic        valid_q;
	logic [15:0] char_q;
	logic        has_q;
	logic        err_q;
	logic        done_q;

	logic [1:0]  mode_d;
	logic [2:0]  digits_d;
	logic [15:0] acc_d;
	logic [15:0] acc_sh;
	logic [2:0]  digits_dec;
	logic        emit;
	logic [15:0] e_char;
	logic        e_has;
	logic        e_err;
	logic        e_done;
	logic        pop;

	// A token is taken when the output register is free or being drained.
	assign tok_ready = !valid_q || out_ready;
	assign pop       = tok_valid && tok_ready;

	assign acc_sh     = {acc_q[11:0], tok.hex_val};
	assign digits_dec = digits_q - 3'd1;

	// Next state and result for the token at the head of the queue.
	always_comb begin
		mode_d   = mode_q;
		digits_d = digits_q;
		acc_d    = acc_q;
		emit     = 1'b0;
		e_char   = '0;
		e_has    = 1'b0;
		e_err    = 1'b0;
		e_done   = tok.eos;
		unique case (mode_q)
			MODE_IDLE: begin
				if (tok.is_bslash) begin
					if (tok.eos) begin
						emit  = 1'b1;
						e_err = 1'b1;
					end else begin
						mode_d = MODE_ESC;
					end
				end else begin
					emit   = 1'b1;
					e_char = tok.ch;
					e_has  = 1'b1;
				end
			end
			MODE_ESC: begin
				if (tok.is_x || tok.is_u) begin
					if (tok.eos) begin
						emit  = 1'b1;
						e_err = 1'b1;
					end else begin
						mode_d   = MODE_HEX;
						digits_d = tok.is_x ? DIGITS_X : DIGITS_U;
						acc_d    = '0;
					end
				end else begin
					mode_d = MODE_IDLE;
					emit   = 1'b1;
					e_char = tok.esc_val;
					e_has  = 1'b1;
				end
			end
			MODE_HEX: begin
				if (!tok.hex_ok) begin
					emit     = 1'b1;
					e_err    = 1'b1;
					mode_d   = MODE_DROP;
					digits_d = '0;
					acc_d    = '0;
				end else if (digits_dec == '0) begin
					emit   = 1'b1;
					e_char = acc_sh;
					e_has  = 1'b1;
					mode_d = MODE_IDLE;
					acc_d  = '0;
					digits_d = '0;
				end else if (tok.eos) begin
					emit  = 1'b1;
					e_err = 1'b1;
				end else begin
					acc_d    = acc_sh;
					digits_d = digits_dec;
				end
			end
			default: begin
				// Dropping the rest of a malformed string until its end.
				if (tok.eos) begin
					emit  = 1'b1;
					e_err = 1'b1;
				end
			end
		endcase
		// The end of a string always returns the decoder to its reset state.
		if (tok.eos) begin
			mode_d   = MODE_IDLE;
			digits_d = '0;
			acc_d    = '0;
		end
	end

	// Decoder state and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			digits_q <= '0;
			acc_q    <= '0;
			valid_q  <= 1'b0;
		end else begin
			if (pop) begin
				mode_q   <= mode_d;
				digits_q <= digits_d;
				acc_q    <= acc_d;
			end
			if (tok_ready) begin
				valid_q <= pop && emit;
			end
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			char_q <= e_char;
			has_q  <= e_has;
			err_q  <= e_err;
			done_q <= e_done;
		end
	end

	assign out_valid    = valid_q;
	assign out_char     = char_q;
	assign out_has_char = has_q;
	assign out_error    = err_q;
	assign out_done     = done_q;

endmodule

`default_nettype wire

// File: hw/rtl/escape_sequence_decoder_top.sv
// Top level of the escape sequence decoder: front end, token queue and back end.
// Depends on esd_pkg, esd_front, esd_fifo and esd_back.
//
// Channel   Direction  Signals                          Carries
// s_*       in         s_tvalid s_tready s_tdata s_tlast  one character per request
// m_*       out        m_tvalid m_tready m_tdata m_tlast m_tuser  zero or one result per char
//
// One character is taken per cycle, sustained, while the output side keeps taking results;
// a result is offered once its character has passed the front register, the token queue
// and the output register, in that order.
// Reset clears all control state at once; no clearing pass is needed.
// The token queue of FIFO_DEPTH entries lets the input keep flowing while the
// output side is stalled, until the queue fills.
`default_nettype none

module escape_sequence_decoder_top #(
	parameter int FIFO_DEPTH = 4   // at least 2
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [15:0] s_tdata,   // [15:0] char_code
	input  wire         s_tlast,   // end_of_string
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [15:0] m_tdata,   // [15:0] char_value
	output logic        m_tlast,   // string_done
	output logic [1:0]  m_tuser    // [0] has_char, [1] parse_error
);
	import esd_pkg::*;

	logic      f_valid;
	logic      f_ready;
	esd_tok_t  f_tok;
	logic      q_valid;
	logic      q_ready;
	esd_tok_t  q_tok;

	esd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_ch     (s_tdata),
		.in_eos    (s_tlast),
		.tok_valid (f_valid),
		.tok_ready (f_ready),
		.tok       (f_tok)
	);

	esd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_tok   (f_tok),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_tok   (q_tok)
	);

	esd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.tok_valid    (q_valid),
		.tok_ready    (q_ready),
		.tok          (q_tok),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_char     (m_tdata),
		.out_has_char (m_tuser[0]),
		.out_error    (m_tuser[1]),
		.out_done     (m_tlast)
	);

endmodule

`default_nettype wire

// File: tb/escape_sequence_decoder_top_test.sv
// Self-checking testbench for escape_sequence_decoder_top: drives strings of characters and
// checks every decoded result against a predictor that decodes the same requests in step.
// Depends on esd_pkg and the RTL of the decoder; needs no files or arguments.
`timescale 1ns / 1ps

import esd_pkg::*;

typedef enum logic [1:0] {
	DEC_IDLE,
	DEC_ESC,
	DEC_HEX,
	DEC_DROP
} dec_mode_t;

typedef struct packed {
	logic [15:0] value;
	logic        has_char;
	logic        parse_error;
	logic        string_done;
} dec_result_t;

// Predicts the decoded result of each accepted character and checks results in order.
class esc_decode_scoreboard;
	dec_mode_t   mode;
	bit [2:0]    digits_left;
	bit [15:0]   hex_acc;
	dec_result_t expected_q[$];
	int unsigned mismatches;

	function new();
		clear_state();
		mismatches = 0;
	endfunction

	function void clear_state();
		mode = DEC_IDLE;
		digits_left = '0;
		hex_acc = '0;
	endfunction

	function int hex_digit(logic [15:0] c);
		if (c >= CH_DIG0 && c <= CH_DIG9) return int'(c - CH_DIG0);
		if (c >= CH_LA && c <= CH_LF) return int'(c - CH_LA) + 10;
		if (c >= CH_UA && c <= CH_UF) return int'(c - CH_UA) + 10;
		return -1;
	endfunction

	function void push_result(logic [15:0] value, logic has, logic err, logic done);
		dec_result_t r;
		r.value = value;
		r.has_char = has;
		r.parse_error = err;
		r.string_done = done;
		expected_q.push_back(r);
		if (done) clear_state();
	endfunction

	// A malformed escape drops the rest of the string unless it is already at its end.
	function void flag_error(logic done);
		if (!done) begin
			mode = DEC_DROP;
			digits_left = '0;
			hex_acc = '0;
		end
		push_result('0, 1'b0, 1'b1, done);
	endfunction

	function void note_request(logic [15:0] ch, logic eos);
		int d;
		case (mode)
			DEC_IDLE: begin
				if (ch == CH_BSLASH) begin
					if (eos) flag_error(1'b1);
					else mode = DEC_ESC;
				end else begin
					push_result(ch, 1'b1, 1'b0, eos);
				end
			end
			DEC_ESC: begin
				if (ch == CH_LX || ch == CH_LU) begin
					if (eos) begin
						flag_error(1'b1);
					end else begin
						mode = DEC_HEX;
						digits_left = (ch == CH_LX) ? DIGITS_X : DIGITS_U;
						hex_acc = '0;
					end
				end else begin
					mode = DEC_IDLE;
					case (ch)
						CH_LA: push_result(CC_BEL, 1'b1, 1'b0, eos);
						CH_LB: push_result(CC_BS, 1'b1, 1'b0, eos);
						CH_LF: push_result(CC_FF, 1'b1, 1'b0, eos);
						CH_LN: push_result(CC_LF, 1'b1, 1'b0, eos);
						CH_LR: push_result(CC_CR, 1'b1, 1'b0, eos);
						CH_LT: push_result(CC_HT, 1'b1, 1'b0, eos);
						CH_LV: push_result(CC_VT, 1'b1, 1'b0, eos);
						default: push_result(ch, 1'b1, 1'b0, eos);
					endcase
				end
			end
			DEC_HEX: begin
				d = hex_digit(ch);
				if (d < 0) begin
					flag_error(eos);
				end else begin
					hex_acc = {hex_acc[11:0], 4'(d)};
					digits_left = digits_left - 3'd1;
					if (digits_left == 0) begin
						mode = DEC_IDLE;
						push_result(hex_acc, 1'b1, 1'b0, eos);
					end else if (eos) begin
						flag_error(1'b1);
					end
				end
			end
			default: begin
				if (eos) push_result('0, 1'b0, 1'b1, 1'b1);
			end
		endcase
	endfunction

	function void check_result(logic [15:0] value, logic [1:0] flags, logic done);
		dec_result_t e;
		if (expected_q.size() == 0) begin
			$error("result with nothing expected: char_value %h flags %b string_done %b",
				value, flags, done);
			mismatches++;
			return;
		end
		e = expected_q.pop_front();
		if (value !== e.value) begin
			$error("char_value: expected %h, got %h", e.value, value);
			mismatches++;
		end
		if (flags[0] !== e.has_char) begin
			$error("has_char: expected %b, got %b", e.has_char, flags[0]);
			mismatches++;
		end
		if (flags[1] !== e.parse_error) begin
			$error("parse_error: expected %b, got %b", e.parse_error, flags[1]);
			mismatches++;
		end
		if (done !== e.string_done) begin
			$error("string_done: expected %b, got %b", e.string_done, done);
			mismatches++;
		end
	endfunction
endclass

module escape_sequence_decoder_top_test;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 500;
	localparam int QUIET_ITEMS   = 60;
	localparam int HOLD_CYCLES   = 150;
	localparam int HOLD_AFTER    = 120;
	localparam int DRAIN_CYCLES  = 10;

	typedef struct {
		logic [15:0] code;
		logic        last;
	} char_req_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;

	esc_decode_scoreboard sb = new();
	char_req_t   char_q[$];
	int unsigned accepted_chars = 0;
	int unsigned cycle_count = 0;
	bit          quiet_phase = 0;
	bit          hold_done = 0;

	escape_sequence_decoder_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Watchdog against a hung handshake.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Handshakes are sampled mid-cycle, when every signal has settled for the coming edge.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tdata, s_tlast);
				accepted_chars++;
			end
			if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
		end
	end

	function automatic void add_char(logic [15:0] code, logic last = 1'b0);
		char_req_t r;
		r.code = code;
		r.last = last;
		char_q.push_back(r);
	endfunction

	function automatic logic [15:0] rand_hex_char();
		int r;
		r = $urandom_range(0, 21);
		if (r < 10) return CH_DIG0 + 16'(r);
		if (r < 16) return CH_LA + 16'(r - 10);
		return CH_UA + 16'(r - 16);
	endfunction

	// Characters just outside the hex digit ranges, plus arbitrary wide code units.
	function automatic logic [15:0] rand_bad_hex();
		case ($urandom_range(0, 7))
			0: return CH_DIG0 - 16'd1;
			1: return CH_DIG9 + 16'd1;
			2: return CH_UA - 16'd1;
			3: return CH_UF + 16'd1;
			4: return CH_LA - 16'd1;
			5: return CH_LF + 16'd1;
			default: return 16'($urandom_range(16'h0080, 16'hFFFF));
		endcase
	endfunction

	// Receiver: random stalls, one long hold-off to fill the token queue, none at the end.
	initial begin
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && accepted_chars >= HOLD_AFTER) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1;
				m_tready <= 1'b1;
				@(posedge clk);
			end else if (!quiet_phase && $urandom_range(0, 9) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Stimulus build, sender and end of run.
	initial begin
		int          n_tokens;
		int          need;
		int          have;
		logic [15:0] letters [8];

		letters = '{CH_LA, CH_LB, CH_LF, CH_LN, CH_LR, CH_LT, CH_LV, 16'h0000};
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tlast  <= 1'b0;
		m_tready <= 1'b0;

		// Directed strings: extremes, escapes, hex forms and every way of going wrong.
		add_char(16'hFFFF);
		add_char(16'h0000, 1'b1);
		add_char(CH_BSLASH); add_char(CH_LA);
		add_char(CH_BSLASH); add_char(CH_BSLASH, 1'b1);
		add_char(CH_BSLASH); add_char(CH_LX); add_char(CH_UF); add_char(CH_LF, 1'b1);
		add_char(CH_BSLASH); add_char(CH_LU); add_char(CH_DIG0); add_char(CH_LA);
		add_char(CH_UA + 16'd1); add_char(CH_DIG9, 1'b1);
		// Bad digit mid string, then dropped characters up to the end item.
		add_char(CH_BSLASH); add_char(CH_LX); add_char(CH_LF + 16'd1);
		add_char(CH_LU); add_char(CH_LR, 1'b1);
		// Strings that end inside an escape.
		add_char(CH_BSLASH, 1'b1);
		add_char(CH_BSLASH); add_char(CH_LU, 1'b1);
		add_char(CH_BSLASH); add_char(CH_LX); add_char(CH_DIG0 + 16'd1, 1'b1);
		// Bad digit on the end item itself.
		add_char(CH_BSLASH); add_char(CH_LX); add_char(CH_UF + 16'd1, 1'b1);

		// Random strings, mostly well-formed: plain characters and escapes with random content.
		while (char_q.size() < RANDOM_ITEMS + 30) begin
			n_tokens = $urandom_range(1, 6);
			for (int t = 0; t < n_tokens; t++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5: add_char(16'($urandom_range(0, 16'hFFFF)));
					6, 7, 8: begin
						add_char(CH_BSLASH);
						add_char(letters[$urandom_range(0, 6)]);
					end
					9: begin
						add_char(CH_BSLASH);
						add_char(16'($urandom_range(0, 16'hFFFF)));
					end
					10, 11, 12, 13, 14, 15: begin
						need = ($urandom_range(0, 1) == 0) ? 2 : 4;
						add_char(CH_BSLASH);
						add_char((need == 2) ? CH_LX : CH_LU);
						for (int k = 0; k < need; k++) add_char(rand_hex_char());
					end
					16, 17: begin
						need = ($urandom_range(0, 1) == 0) ? 2 : 4;
						have = $urandom_range(0, need - 1);
						add_char(CH_BSLASH);
						add_char((need == 2) ? CH_LX : CH_LU);
						for (int k = 0; k < have; k++) add_char(rand_hex_char());
						add_char(rand_bad_hex());
					end
					default: begin
						// Truncated escape: whatever follows decides its fate.
						need = ($urandom_range(0, 1) == 0) ? 2 : 4;
						have = $urandom_range(0, need - 1);
						add_char(CH_BSLASH);
						add_char((need == 2) ? CH_LX : CH_LU);
						for (int k = 0; k < have; k++) add_char(rand_hex_char());
					end
				endcase
			end
			char_q[char_q.size() - 1].last = 1'b1;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Each request is offered until accepted; gaps fall between requests.
		foreach (char_q[i]) begin
			if (i >= char_q.size() - QUIET_ITEMS) quiet_phase = 1;
			if (!quiet_phase && $urandom_range(0, 7) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= char_q[i].code;
			s_tlast  <= char_q[i].last;
			do @(negedge clk); while (!s_tready);
			@(posedge clk);
		end
		s_tvalid <= 1'b0;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
